// ===== rtl/dlm_pkg.sv =====
package dlm_pkg;

    // Frame geometry and stream layout.
    localparam int NCOLS      = 10;
    localparam int NROWS      = 7;
    localparam int GLYPH_W    = 5;
    localparam int STREAM_LEN = 18;
    localparam int IDX_W      = $clog2(STREAM_LEN);
    localparam int COL_W      = 4;
    localparam int ROW_W      = 3;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(STREAM_LEN - 1);
    localparam logic [7:0]       LEFT_DP     = 8'h40;
    localparam logic [7:0]       RIGHT_DP    = 8'h80;
    localparam logic [6:0]       FIRST_PRINT = 7'd32;

    // Request codes; the two unused codes are ignored.
    typedef enum logic [2:0] {
        REQ_PLOT   = 3'd0,
        REQ_COLUMN = 3'd1,
        REQ_CHAR   = 3'd2,
        REQ_POINT  = 3'd3,
        REQ_CLEAR  = 3'd4,
        REQ_DRAW   = 3'd5
    } req_t;

    // One registered command word.
    typedef struct packed {
        logic [2:0]       req_type;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             ink;
        logic [6:0]       column_bits;
        logic [6:0]       char_code;
        logic             display_side;
    } cmd_t;

    typedef logic [NCOLS-1:0][6:0]   cols_t;
    typedef logic [GLYPH_W-1:0][6:0] half_t;

    // Frame contents as seen by the stream side.
    typedef struct packed {
        cols_t cols;
        logic  left_point;
        logic  right_point;
    } frame_t;

    // Reverses the order of the seven low bits.
    function automatic logic [6:0] rev7(input logic [6:0] v);
        logic [6:0] o;
        for (int i = 0; i < 7; i++)
        begin
            o[6-i] = v[i];
        end
        return o;
    endfunction

    // Font for codes 32..127, first column in the top byte.
    function automatic logic [39:0] font_row(input logic [6:0] idx);
        logic [39:0] g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'hfa00000000;
            7'd2:  g = 40'hc000000000;
            7'd3:  g = 40'h247e247e24;
            7'd4:  g = 40'h24d4564800;
            7'd5:  g = 40'hc6c81026c6;
            7'd6:  g = 40'h6c926a040a;
            7'd7:  g = 40'hc000000000;
            7'd8:  g = 40'h7c82000000;
            7'd9:  g = 40'h827c000000;
            7'd10: g = 40'h107c387c10;
            7'd11: g = 40'h10107c1010;
            7'd12: g = 40'h0607000000;
            7'd13: g = 40'h1010101000;
            7'd14: g = 40'h0606000000;
            7'd15: g = 40'h0408102040;
            7'd16: g = 40'h7c8a92a27c;
            7'd17: g = 40'h42fe020000;
            7'd18: g = 40'h468a929262;
            7'd19: g = 40'h449292926c;
            7'd20: g = 40'h182848fe08;
            7'd21: g = 40'hf49292928c;
            7'd22: g = 40'h3c5292928c;
            7'd23: g = 40'h808e90a0c0;
            7'd24: g = 40'h6c9292926c;
            7'd25: g = 40'h6092929478;
            7'd26: g = 40'h3636000000;
            7'd27: g = 40'h3637000000;
            7'd28: g = 40'h1028448200;
            7'd29: g = 40'h2424242424;
            7'd30: g = 40'h8244281000;
            7'd31: g = 40'h60809a9060;
            7'd32: g = 40'h7c82baaa78;
            7'd33: g = 40'h7e9090907e;
            7'd34: g = 40'hfe9292926c;
            7'd35: g = 40'h7c82828244;
            7'd36: g = 40'hfe8282827c;
            7'd37: g = 40'hfe92929282;
            7'd38: g = 40'hfe90909080;
            7'd39: g = 40'h7c8292925c;
            7'd40: g = 40'hfe101010fe;
            7'd41: g = 40'h82fe820000;
            7'd42: g = 40'h0c020202fc;
            7'd43: g = 40'hfe10284482;
            7'd44: g = 40'hfe02020200;
            7'd45: g = 40'hfe402040fe;
            7'd46: g = 40'hfe402010fe;
            7'd47: g = 40'h7c8282827c;
            7'd48: g = 40'hfe90909060;
            7'd49: g = 40'h7c82928c7a;
            7'd50: g = 40'hfe90909866;
            7'd51: g = 40'h649292924c;
            7'd52: g = 40'h8080fe8080;
            7'd53: g = 40'hfc020202fc;
            7'd54: g = 40'hf8040204f8;
            7'd55: g = 40'hfc023c02fc;
            7'd56: g = 40'hc6281028c6;
            7'd57: g = 40'he0100e10e0;
            7'd58: g = 40'h868a92a2c2;
            7'd59: g = 40'hfe82820000;
            7'd60: g = 40'h4020100804;
            7'd61: g = 40'h8282fe0000;
            7'd62: g = 40'h2040804020;
            7'd63: g = 40'h0202020202;
            7'd64: g = 40'hc0e0000000;
            7'd65: g = 40'h042a2a1e00;
            7'd66: g = 40'hfe22221c00;
            7'd67: g = 40'h1c22222200;
            7'd68: g = 40'h1c2222fc00;
            7'd69: g = 40'h1c2a2a1000;
            7'd70: g = 40'h107e908000;
            7'd71: g = 40'h102a2a3c00;
            7'd72: g = 40'hfe20201e00;
            7'd73: g = 40'h5e00000000;
            7'd74: g = 40'h0402125c00;
            7'd75: g = 40'hfe08142200;
            7'd76: g = 40'hfc02000000;
            7'd77: g = 40'h3e2018201e;
            7'd78: g = 40'h3e2020201e;
            7'd79: g = 40'h1c22221c00;
            7'd80: g = 40'h3e24241800;
            7'd81: g = 40'h1824243e00;
            7'd82: g = 40'h221e201000;
            7'd83: g = 40'h122a2a0400;
            7'd84: g = 40'h207c220400;
            7'd85: g = 40'h3c02023e00;
            7'd86: g = 40'h3804020438;
            7'd87: g = 40'h3c060c063c;
            7'd88: g = 40'h2214081422;
            7'd89: g = 40'h320a0c3800;
            7'd90: g = 40'h262a2a3200;
            7'd91: g = 40'h107c828200;
            7'd92: g = 40'hee00000000;
            7'd93: g = 40'h82827c1000;
            7'd94: g = 40'h4080408000;
            7'd95: g = 40'h6090906000;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

    // Builds the five columns of one half for a printable code.
    // The glyph width is the number of bytes before the first zero byte,
    // and the glyph is placed at a fixed offset that depends on that width.
    function automatic half_t render_half(input logic [6:0] code);
        logic [39:0]              g;
        logic [GLYPH_W-1:0][7:0]  gb;
        logic [2:0]               n;
        logic [2:0]               d;
        logic [2:0]               x;
        half_t                    h;
        g = font_row(code - FIRST_PRINT);
        for (int i = 0; i < GLYPH_W; i++)
        begin
            gb[i] = g[39-8*i -: 8];
        end
        n = 3'd5;
        for (int i = GLYPH_W - 1; i >= 0; i--)
        begin
            if (gb[i] == 8'd0)
            begin
                n = 3'(i);
            end
        end
        case (n)
            3'd0:    d = 3'd3;
            3'd1:    d = 3'd2;
            3'd2:    d = 3'd2;
            3'd3:    d = 3'd1;
            3'd4:    d = 3'd1;
            default: d = 3'd0;
        endcase
        for (int c = 0; c < GLYPH_W; c++)
        begin
            x = 3'(c) - d;
            if ((3'(c) >= d) && (x < n))
            begin
                h[c] = rev7(gb[x][7:1]);
            end
            else
            begin
                h[c] = 7'd0;
            end
        end
        return h;
    endfunction

endpackage

// ===== rtl/dual_led_matrix_frame_mapper.sv =====
// A command is registered on acceptance and applied to the frame once no stream is running.
// Throughput: one command per cycle while no stream runs; a draw streams 18 words at one per
// cycle while out_ready is high, and the command register holds the next command until the
// last word is loaded. Reset clears the frame, both decimal points, the flip register and all
// handshake state.
module dual_led_matrix_frame_mapper
    import dlm_pkg::*;
#(
    parameter logic [7:0] LEFT_HEADER  = 8'd14,
    parameter logic [7:0] RIGHT_HEADER = 8'd1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             flip,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       req_type,
    input  logic [COL_W-1:0] column,
    input  logic [ROW_W-1:0] row,
    input  logic             ink,
    input  logic [6:0]       column_bits,
    input  logic [6:0]       char_code,
    input  logic             display_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             last
);

    logic   flip_reg;
    logic   cmd_valid_reg;
    logic   cmd_valid_next;
    cmd_t   cmd_reg;
    logic   busy;
    logic   consume;
    logic   apply;
    logic   start;
    frame_t frame;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            flip_reg <= flip;
        end
    end

    // The command register drains only while no stream is running.
    assign consume  = cmd_valid_reg && !busy;
    assign in_ready = !cmd_valid_reg || consume;
    assign start    = consume && (req_t'(cmd_reg.req_type) == REQ_DRAW);
    assign apply    = consume;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (in_valid && in_ready)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (consume)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // Command word register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg.req_type     <= req_type;
            cmd_reg.column       <= column;
            cmd_reg.row          <= row;
            cmd_reg.ink          <= ink;
            cmd_reg.column_bits  <= column_bits;
            cmd_reg.char_code    <= char_code;
            cmd_reg.display_side <= display_side;
        end
    end

    // Frame store.
    dlm_frame u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (apply),
        .cmd   (cmd_reg),
        .frame (frame)
    );

    // Driver word stream.
    dlm_stream #(
        .LEFT_HEADER  (LEFT_HEADER),
        .RIGHT_HEADER (RIGHT_HEADER)
    ) u_stream (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .frame     (frame),
        .flip      (flip_reg),
        .out_ready (out_ready),
        .busy      (busy),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

// ===== rtl/dlm_frame.sv =====
module dlm_frame
    import dlm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   apply,
    input  cmd_t   cmd,
    output frame_t frame
);

    cols_t cols_reg;
    cols_t cols_next;
    logic  left_point_reg;
    logic  left_point_next;
    logic  right_point_reg;
    logic  right_point_next;
    half_t glyph;

    // Glyph columns for the character command.
    assign glyph = render_half(cmd.char_code);

    // Next frame contents for the current command.
    always_comb
    begin
        cols_next        = cols_reg;
        left_point_next  = left_point_reg;
        right_point_next = right_point_reg;
        if (apply)
        begin
            unique case (req_t'(cmd.req_type))
                REQ_PLOT:
                begin
                    if ((cmd.column < COL_W'(NCOLS)) && (cmd.row < ROW_W'(NROWS)))
                    begin
                        cols_next[cmd.column][cmd.row] = cmd.ink;
                    end
                end
                REQ_COLUMN:
                begin
                    if (cmd.column < COL_W'(NCOLS))
                    begin
                        cols_next[cmd.column] = cmd.column_bits;
                    end
                end
                REQ_CHAR:
                begin
                    if (cmd.char_code >= FIRST_PRINT)
                    begin
                        for (int c = 0; c < GLYPH_W; c++)
                        begin
                            if (cmd.display_side)
                            begin
                                cols_next[GLYPH_W + c] = glyph[c];
                            end
                            else
                            begin
                                cols_next[c] = glyph[c];
                            end
                        end
                    end
                end
                REQ_POINT:
                begin
                    if (cmd.display_side)
                    begin
                        right_point_next = 1'b1;
                    end
                    else
                    begin
                        left_point_next = 1'b1;
                    end
                end
                REQ_CLEAR:
                begin
                    cols_next = '0;
                end
                default:
                begin
                    cols_next = cols_reg;
                end
            endcase
        end
    end

    // Frame and point registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg        <= '0;
            left_point_reg  <= 1'b0;
            right_point_reg <= 1'b0;
        end
        else
        begin
            cols_reg        <= cols_next;
            left_point_reg  <= left_point_next;
            right_point_reg <= right_point_next;
        end
    end

    assign frame.cols        = cols_reg;
    assign frame.left_point  = left_point_reg;
    assign frame.right_point = right_point_reg;

endmodule

// ===== rtl/dlm_stream.sv =====
module dlm_stream
    import dlm_pkg::*;
#(
    parameter logic [7:0] LEFT_HEADER  = 8'd14,
    parameter logic [7:0] RIGHT_HEADER = 8'd1
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  frame_t     frame,
    input  logic       flip,
    input  logic       out_ready,
    output logic       busy,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       last
);

    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               busy_reg;
    logic               busy_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    logic               last_reg;
    logic               load;
    logic [4:0][6:0]    left_bytes;
    logic [NROWS-1:0][4:0] right_rows;
    logic [7:0]         byte_sel;

    // Left digit columns and right digit rows, with optional rotation.
    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            left_bytes[j] = flip ? rev7(frame.cols[NCOLS - 1 - j]) : frame.cols[j];
        end
        for (int y = 0; y < NROWS; y++)
        begin
            for (int i = 0; i < 5; i++)
            begin
                right_rows[y][i] = flip ? frame.cols[4 - i][NROWS - 1 - y]
                                        : frame.cols[5 + i][y];
            end
        end
    end

    // Byte selection by stream position.
    always_comb
    begin
        case (idx_reg)
            5'd0:  byte_sel = LEFT_HEADER;
            5'd1:  byte_sel = {1'b0, left_bytes[0]};
            5'd2:  byte_sel = {1'b0, left_bytes[1]};
            5'd3:  byte_sel = {1'b0, left_bytes[2]};
            5'd4:  byte_sel = {1'b0, left_bytes[3]};
            5'd5:  byte_sel = {1'b0, left_bytes[4]};
            5'd8:  byte_sel = frame.left_point ? LEFT_DP : 8'd0;
            5'd9:  byte_sel = RIGHT_HEADER;
            5'd10: byte_sel = {3'd0, right_rows[0]};
            5'd11: byte_sel = {3'd0, right_rows[1]};
            5'd12: byte_sel = {3'd0, right_rows[2]};
            5'd13: byte_sel = {3'd0, right_rows[3]};
            5'd14: byte_sel = {3'd0, right_rows[4]};
            5'd15: byte_sel = {3'd0, right_rows[5]};
            5'd16: byte_sel = {3'd0, right_rows[6]} | (frame.right_point ? RIGHT_DP : 8'd0);
            default: byte_sel = 8'd0;
        endcase
    end

    // While a stream runs, a byte moves into the output register whenever that register is free.
    assign load = busy_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            if (idx_reg == LAST_IDX)
            begin
                idx_next  = '0;
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        else if (start)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_sel;
            last_reg     <= (idx_reg == LAST_IDX);
        end
    end

    assign busy      = busy_reg;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    // A draw starts only while no stream is running.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("draw started while a stream is running");

    // The position counter never passes the final word.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("stream position out of range");

    // Loading the final word ends the stream and flags it as last.
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (idx_reg == LAST_IDX)) |=> (!busy_reg && last_reg && out_valid_reg))
        else $error("final word did not end the stream");

    // Only the final word carries the last flag.
    a_last_only: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (idx_reg != LAST_IDX)) |=> !last_reg)
        else $error("last flag on an inner word");

endmodule
